// ----- rtl/assert_macros.svh -----
// assertion helpers, clocked on the rising edge, held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// invariant
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

`endif

// ----- rtl/ifscg_pkg.sv -----
`default_nettype none

package ifscg_pkg;

    typedef logic signed [31:0] t_coord;

    typedef enum logic [2:0] {
        CFG_MAP0   = 3'd0,
        CFG_MAP1   = 3'd1,
        CFG_MAP2   = 3'd2,
        CFG_MAP3   = 3'd3,
        CFG_SHIFT01 = 3'd4,
        CFG_SHIFT23 = 3'd5,
        CFG_THRESH = 3'd6,
        CFG_BURN   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_coord     x;
        t_coord     y;
        logic [1:0] map;
    } t_step;

    typedef struct packed {
        t_coord     point_x;
        t_coord     point_y;
        logic [1:0] map_index;
        logic       counted;
        t_coord     box_min_x;
        t_coord     box_max_x;
        t_coord     box_min_y;
        t_coord     box_max_y;
    } t_result;

    localparam t_coord     COORD_MAX  = 32'sh7FFF_FFFF;
    localparam t_coord     COORD_MIN  = 32'sh8000_0000;
    localparam logic [7:0] BURN_RESET = 8'd26;
    localparam logic [7:0] SEEN_MAX   = 8'd255;

endpackage

`default_nettype wire

// ----- rtl/ifscg_req_if.sv -----
`default_nettype none

interface ifscg_req_if;
    logic        valid;
    logic        ready;
    logic [19:0] choice_value;
    logic        start_req;

    modport source (output valid, output choice_value, output start_req, input ready);
    modport sink   (input valid, input choice_value, input start_req, output ready);
endinterface

`default_nettype wire

// ----- rtl/ifscg_res_if.sv -----
`default_nettype none

interface ifscg_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         map_index;
    logic               counted;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_y;

    modport source (
        output valid, output point_x, output point_y, output map_index, output counted,
        output box_min_x, output box_max_x, output box_min_y, output box_max_y,
        input ready
    );
    modport sink (
        input valid, input point_x, input point_y, input map_index, input counted,
        input box_min_x, input box_max_x, input box_min_y, input box_max_y,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/ifs_chaos_game_point_generator_core.sv -----
// channel   dir  payload
// i_req     in   choice_value[19:0], start_req
// o_res     out  point_x/y, map_index, counted, box_min/max_x/y
// i_cfg_*   in   we, idx[2:0], data[63:0]
//
// one request per cycle while the buffer has space; the point update is combinational
// through four 16x32 products; each result is registered into a two-entry output buffer
// i_req.ready is buffer occupancy only, no path from o_res.ready
// a full buffer holds requests off, ready returns the cycle after a result leaves
// synchronous active-low reset, burn-in resets to 26, other config to zero, box to empty
`default_nettype none
`include "assert_macros.svh"

module ifs_chaos_game_point_generator_core
    import ifscg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ifscg_req_if.sink        i_req,
    ifscg_res_if.source      o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    logic [3:0][63:0] r_mat;
    logic [1:0][63:0] r_shift;
    logic [59:0]      r_thresh;
    logic [7:0]       r_burn;

    t_coord     r_cur_x, r_cur_y;
    logic [7:0] r_seen;
    t_coord     r_min_x, r_max_x, r_min_y, r_max_y;

    logic       w_acc;
    logic       w_space;
    t_coord     w_cx, w_cy;
    logic [7:0] w_seen;
    t_coord     w_min_x, w_max_x, w_min_y, w_max_y;
    t_step      w_step;
    logic       w_counted;
    t_result    w_res;

    assign i_req.ready = w_space;
    assign w_acc       = i_req.valid && w_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat    <= '0;
            r_shift  <= '0;
            r_thresh <= '0;
            r_burn   <= BURN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAP0:    r_mat[0]   <= i_cfg_data;
                CFG_MAP1:    r_mat[1]   <= i_cfg_data;
                CFG_MAP2:    r_mat[2]   <= i_cfg_data;
                CFG_MAP3:    r_mat[3]   <= i_cfg_data;
                CFG_SHIFT01: r_shift[0] <= i_cfg_data;
                CFG_SHIFT23: r_shift[1] <= i_cfg_data;
                CFG_THRESH:  r_thresh   <= i_cfg_data[59:0];
                CFG_BURN:    r_burn     <= i_cfg_data[7:0];
                default:     r_burn     <= r_burn;
            endcase
        end
    end

    // start clears the run before the step
    always_comb begin
        if (i_req.start_req) begin
            w_cx    = '0;
            w_cy    = '0;
            w_seen  = '0;
            w_min_x = COORD_MAX;
            w_max_x = COORD_MIN;
            w_min_y = COORD_MAX;
            w_max_y = COORD_MIN;
        end else begin
            w_cx    = r_cur_x;
            w_cy    = r_cur_y;
            w_seen  = r_seen;
            w_min_x = r_min_x;
            w_max_x = r_max_x;
            w_min_y = r_min_y;
            w_max_y = r_max_y;
        end
    end

    ifscg_step u_step (
        .i_choice (i_req.choice_value),
        .i_thresh (r_thresh),
        .i_mat    (r_mat),
        .i_shift  (r_shift),
        .i_cur_x  (w_cx),
        .i_cur_y  (w_cy),
        .o_step   (w_step)
    );

    assign w_counted = (w_seen >= r_burn);

    always_comb begin
        w_res.point_x   = w_step.x;
        w_res.point_y   = w_step.y;
        w_res.map_index = w_step.map;
        w_res.counted   = w_counted;
        w_res.box_min_x = (w_counted && (w_step.x < w_min_x)) ? w_step.x : w_min_x;
        w_res.box_max_x = (w_counted && (w_step.x > w_max_x)) ? w_step.x : w_max_x;
        w_res.box_min_y = (w_counted && (w_step.y < w_min_y)) ? w_step.y : w_min_y;
        w_res.box_max_y = (w_counted && (w_step.y > w_max_y)) ? w_step.y : w_max_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_seen  <= '0;
            r_min_x <= COORD_MAX;
            r_max_x <= COORD_MIN;
            r_min_y <= COORD_MAX;
            r_max_y <= COORD_MIN;
        end else if (w_acc) begin
            r_cur_x <= w_step.x;
            r_cur_y <= w_step.y;
            r_seen  <= (w_seen == SEEN_MAX) ? w_seen : w_seen + 8'd1;
            r_min_x <= w_res.box_min_x;
            r_max_x <= w_res.box_max_x;
            r_min_y <= w_res.box_min_y;
            r_max_y <= w_res.box_max_y;
        end
    end

    ifscg_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_res),
        .o_space (w_space),
        .o_res   (o_res)
    );

    `ASSERT_NEXT(a_start_seen, i_clk, i_rst_n, w_acc && i_req.start_req, r_seen == 8'd1)
    `ASSERT_NEXT(a_seen_sat, i_clk, i_rst_n, w_acc && (r_seen == SEEN_MAX) && !i_req.start_req,
                 r_seen == SEEN_MAX)
    `ASSERT_ALWAYS(a_box_order, i_clk, i_rst_n,
                   ((r_min_x <= r_max_x) && (r_min_y <= r_max_y)) ||
                   ((r_min_x == COORD_MAX) && (r_max_x == COORD_MIN) &&
                    (r_min_y == COORD_MAX) && (r_max_y == COORD_MIN)))

endmodule

`default_nettype wire

// ----- rtl/ifscg_step.sv -----
`default_nettype none

module ifscg_step
    import ifscg_pkg::*;
(
    input  wire logic [19:0]      i_choice,
    input  wire logic [59:0]      i_thresh,
    input  wire logic [3:0][63:0] i_mat,
    input  wire logic [1:0][63:0] i_shift,
    input  wire t_coord           i_cur_x,
    input  wire t_coord           i_cur_y,
    output t_step                 o_step
);

    localparam logic signed [35:0] LIM_HI = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] LIM_LO = -36'sh0_7FFF_FFFF;

    logic [1:0]         w_map;
    logic [63:0]        w_mat;
    logic [63:0]        w_sh_pair;
    logic [31:0]        w_sh;
    logic signed [15:0] w_a, w_b, w_c, w_d, w_e, w_f;
    logic signed [47:0] w_pax, w_pby, w_pcx, w_pdy;
    logic signed [35:0] w_nx, w_ny;
    logic               w_inside;

    always_comb begin
        priority if (i_choice < i_thresh[19:0]) begin
            w_map = 2'd0;
        end else if (i_choice < i_thresh[39:20]) begin
            w_map = 2'd1;
        end else if (i_choice < i_thresh[59:40]) begin
            w_map = 2'd2;
        end else begin
            w_map = 2'd3;
        end
    end

    assign w_mat     = i_mat[w_map];
    assign w_sh_pair = i_shift[w_map[1]];
    assign w_sh      = w_map[0] ? w_sh_pair[63:32] : w_sh_pair[31:0];

    assign w_a = w_mat[15:0];
    assign w_b = w_mat[31:16];
    assign w_c = w_mat[47:32];
    assign w_d = w_mat[63:48];
    assign w_e = w_sh[15:0];
    assign w_f = w_sh[31:16];

    assign w_pax = w_a * i_cur_x;
    assign w_pby = w_b * i_cur_y;
    assign w_pcx = w_c * i_cur_x;
    assign w_pdy = w_d * i_cur_y;

    // floor shift by 14 is a plain bit select of the product
    assign w_nx = {{2{w_pax[47]}}, w_pax[47:14]} + {{2{w_pby[47]}}, w_pby[47:14]}
                + {{14{w_e[15]}}, w_e, 6'b0};
    assign w_ny = {{2{w_pcx[47]}}, w_pcx[47:14]} + {{2{w_pdy[47]}}, w_pdy[47:14]}
                + {{14{w_f[15]}}, w_f, 6'b0};

    assign w_inside = (w_nx >= LIM_LO) && (w_nx <= LIM_HI)
                   && (w_ny >= LIM_LO) && (w_ny <= LIM_HI);

    always_comb begin
        o_step.map = w_map;
        o_step.x   = w_inside ? w_nx[31:0] : '0;
        o_step.y   = w_inside ? w_ny[31:0] : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/ifscg_obuf.sv -----
`default_nettype none

module ifscg_obuf
    import ifscg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_result   i_data,
    output logic           o_space,
    ifscg_res_if.source    o_res
);

    t_result    r_buf [2];
    t_result    n_buf [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_pop;
    logic       w_wr_idx;

    assign w_pop    = (r_cnt != 2'd0) && o_res.ready;
    assign w_wr_idx = r_cnt[0] ^ w_pop;
    assign o_space  = (r_cnt != 2'd2);

    always_comb begin
        n_buf = r_buf;
        if (w_pop) begin
            n_buf[0] = r_buf[1];
        end
        if (i_push) begin
            n_buf[w_wr_idx] = i_data;
        end
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_buf <= n_buf;
    end

    assign o_res.valid     = (r_cnt != 2'd0);
    assign o_res.point_x   = r_buf[0].point_x;
    assign o_res.point_y   = r_buf[0].point_y;
    assign o_res.map_index = r_buf[0].map_index;
    assign o_res.counted   = r_buf[0].counted;
    assign o_res.box_min_x = r_buf[0].box_min_x;
    assign o_res.box_max_x = r_buf[0].box_max_x;
    assign o_res.box_min_y = r_buf[0].box_min_y;
    assign o_res.box_max_y = r_buf[0].box_max_y;

endmodule

`default_nettype wire
